// ----- src/lfh_pkg.sv -----
package lfh_pkg;

  // Default strip length
  localparam int unsigned PIXELS_DEF = 32;

  // Field widths
  localparam int unsigned HEAT_W = 16;  // 8.8 unsigned heat
  localparam int unsigned MS_W   = 16;
  localparam int unsigned INJ_W  = 8;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned AMT_W  = 32;  // cool_rate * ms_elapsed
  localparam int unsigned COOL_W = 16;

  // APB
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register indexes
  localparam logic REG_COOL = 1'b0;
  localparam logic REG_REV  = 1'b1;

  // Reset values
  localparam logic [COOL_W-1:0] COOL_RST = 16'd65;
  localparam logic              REV_RST  = 1'b0;

  // Control from the sequencer to the heat unit
  typedef struct packed {
    logic en;        // a pixel's stored heat is on the RAM read data
    logic sel_inj;   // writing pixel 0
    logic sel_half;  // writing pixel 1
  } heat_ctrl_t;

endpackage

// ----- src/lfh_if.sv -----
interface lfh_in_if;
  logic                        valid;
  logic                        ready;
  logic [lfh_pkg::MS_W-1:0]    ms_elapsed;
  logic [lfh_pkg::INJ_W-1:0]   inject_heat;

  modport source (output valid, ms_elapsed, inject_heat, input ready);
  modport sink   (input valid, ms_elapsed, inject_heat, output ready);
endinterface

interface lfh_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfh_pkg::PIX_W-1:0]   pixel_heat;
  logic [lfh_pkg::IDX_W-1:0]   pixel_index;
  logic                        last;

  modport source (output valid, pixel_heat, pixel_index, last, input ready);
  modport sink   (input valid, pixel_heat, pixel_index, last, output ready);
endinterface

// ----- src/lfh_ram.sv -----
module lfh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lfh_cfg.sv -----
module lfh_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfh_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfh_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfh_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [lfh_pkg::COOL_W-1:0]    cool_rate_o,
  output logic                          reverse_order_o
);

  logic [lfh_pkg::COOL_W-1:0] cool_q;
  logic                       rev_q;
  logic                       wr;
  logic                       sel_idx;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign sel_idx = paddr[2];  // byte address 4*i, low bits ignored

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_q <= lfh_pkg::COOL_RST;
      rev_q  <= lfh_pkg::REV_RST;
    end else if (wr) begin
      if (sel_idx == lfh_pkg::REG_COOL) begin
        cool_q <= pwdata[lfh_pkg::COOL_W-1:0];
      end else begin
        rev_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_idx == lfh_pkg::REG_COOL) begin
      prdata[lfh_pkg::COOL_W-1:0] = cool_q;
    end else begin
      prdata[0] = rev_q;
    end
  end

  assign cool_rate_o     = cool_q;
  assign reverse_order_o = rev_q;

endmodule

// ----- src/lfh_heat_unit.sv -----
// One pixel per cycle: cool, then average the two cooled pixels below,
// or half pixel 0, or inject into pixel 0.
module lfh_heat_unit (
  input  logic                         clk_i,
  input  lfh_pkg::heat_ctrl_t          ctrl_i,
  input  logic                         store_ok_i,  // store written at least once
  input  logic [lfh_pkg::HEAT_W-1:0]   rdata_i,
  input  logic [lfh_pkg::AMT_W-1:0]    amount_i,
  input  logic [lfh_pkg::INJ_W-1:0]    inject_i,
  output logic [lfh_pkg::HEAT_W-1:0]   wdata_o
);

  logic [lfh_pkg::HEAT_W-1:0] heat;
  logic [lfh_pkg::HEAT_W-1:0] cooled;
  logic [lfh_pkg::HEAT_W-1:0] c1_q;  // cooled pixel i-1
  logic [lfh_pkg::HEAT_W-1:0] c2_q;  // cooled pixel i-2
  logic [lfh_pkg::INJ_W:0]    inj_sum;
  logic [lfh_pkg::HEAT_W:0]   avg_sum;
  logic [lfh_pkg::PIX_W-1:0]  inj_sat;

  // never-written store reads as zero
  assign heat = store_ok_i ? rdata_i : '0;

  always_comb begin
    if (lfh_pkg::AMT_W'(heat) > amount_i) begin
      cooled = heat - amount_i[lfh_pkg::HEAT_W-1:0];
    end else begin
      cooled = '0;
    end
  end

  assign inj_sum = (lfh_pkg::INJ_W+1)'(cooled[lfh_pkg::HEAT_W-1:lfh_pkg::PIX_W])
                 + (lfh_pkg::INJ_W+1)'(inject_i);
  assign inj_sat = inj_sum[lfh_pkg::INJ_W] ? '1 : inj_sum[lfh_pkg::INJ_W-1:0];
  assign avg_sum = (lfh_pkg::HEAT_W+1)'(c1_q) + (lfh_pkg::HEAT_W+1)'(c2_q);

  always_comb begin
    if (ctrl_i.sel_inj) begin
      wdata_o = {inj_sat, {lfh_pkg::PIX_W{1'b0}}};
    end else if (ctrl_i.sel_half) begin
      wdata_o = c1_q >> 1;
    end else begin
      wdata_o = avg_sum[lfh_pkg::HEAT_W:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      c2_q <= c1_q;
      c1_q <= cooled;
    end
  end

endmodule

// ----- src/led_fire_heat_simulation_core.sv -----
// Fire heat simulation for a strip of PIXELS lights.
// in_if carries one frame per item: ms_elapsed (cooling time) and inject_heat.
// out_if returns PIXELS items per frame: pixel_heat, pixel_index (0 first) and
// last on the final one. reverse_order = 1 emits the top pixel first.
// Registers over APB: cool_rate at 0x0 (8.8 heat per ms), reverse_order at 0x4.
// Heat lives in a PIXELS x 16 RAM, one read and one write port.
// Per frame: accept (cooling amount multiplied into a register), then the
// update walk through the shared heat unit, one pixel a cycle, then
// emission (one RAM read, then one item per cycle while the receiver keeps
// ready high). The spacing of accepted frames is set by the RAM read
// port, walked once for the update and once for the readout. in_if.ready
// is high only between frames.
// Reset clears the sequencer, the registers to their defaults, and a
// single store-written flag: until the first frame has finished its update
// the RAM reads as zero, so no clearing pass is needed.
// A stalled receiver holds the output register and pauses RAM reads; the
// frame resumes when ready returns. The last item may still sit in the output
// register while the next frame is accepted.
module led_fire_heat_simulation_core #(
  parameter int unsigned PIXELS = lfh_pkg::PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfh_in_if.sink                        in_if,
  lfh_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfh_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfh_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfh_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(PIXELS);
  localparam int unsigned CW = $clog2(PIXELS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;     // update walk, 0..PIXELS
  logic [CW-1:0]                iss_q, iss_d;     // emission reads issued
  logic [AW-1:0]                ld_q, ld_d;       // emission items loaded
  logic                         pend_q, pend_d;   // RAM read data pending
  logic                         ov_q, ov_d;
  logic                         ok_q, ok_d;       // store written once
  logic [lfh_pkg::AMT_W-1:0]    amount_q;
  logic [lfh_pkg::INJ_W-1:0]    inj_q;
  logic [lfh_pkg::PIX_W-1:0]    heat_q;
  logic [lfh_pkg::IDX_W-1:0]    idx_q;
  logic                         last_q;

  logic [lfh_pkg::COOL_W-1:0]   cool_rate;
  logic                         reverse_order;
  logic                         in_acc;
  logic                         load, issue, ld_last;
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr, emit_addr;
  logic [lfh_pkg::HEAT_W-1:0]   ram_wdata, ram_rdata;
  lfh_pkg::heat_ctrl_t          hctrl;

  lfh_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .cool_rate_o     (cool_rate),
    .reverse_order_o (reverse_order)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;

  // update walk: read pixel cnt, write pixel cnt-1
  assign hctrl.en       = (state_q == ST_UPD) && (cnt_q != '0);
  assign hctrl.sel_inj  = (cnt_q == CW'(1));
  assign hctrl.sel_half = (cnt_q == CW'(2));

  // emission
  assign load    = pend_q && (!ov_q || out_if.ready);
  assign issue   = (state_q == ST_EMIT) && (iss_q < CW'(PIXELS)) && (!pend_q || load);
  assign ld_last = (ld_q == AW'(PIXELS - 1));
  assign emit_addr = reverse_order ? (AW'(PIXELS - 1) - iss_q[AW-1:0]) : iss_q[AW-1:0];

  assign ram_we    = hctrl.en;
  assign ram_waddr = AW'(cnt_q - CW'(1));
  assign ram_re    = ((state_q == ST_UPD) && (cnt_q < CW'(PIXELS))) || issue;
  assign ram_raddr = (state_q == ST_UPD) ? cnt_q[AW-1:0] : emit_addr;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    iss_d   = iss_q;
    ld_d    = ld_q;
    ok_d    = ok_q;
    pend_d  = issue ? 1'b1 : (load ? 1'b0 : pend_q);
    ov_d    = load ? 1'b1 : (out_if.ready ? 1'b0 : ov_q);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPD;
          cnt_d   = '0;
        end
      end
      ST_UPD: begin
        if (cnt_q == CW'(PIXELS)) begin
          state_d = ST_EMIT;
          ok_d    = 1'b1;
          iss_d   = '0;
          ld_d    = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_EMIT: begin
        if (issue) begin
          iss_d = iss_q + CW'(1);
        end
        if (load) begin
          ld_d = ld_q + AW'(1);
          if (ld_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      iss_q   <= '0;
      ld_q    <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      ld_q    <= ld_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
      ok_q    <= ok_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      amount_q <= lfh_pkg::AMT_W'(cool_rate) * lfh_pkg::AMT_W'(in_if.ms_elapsed);
      inj_q    <= in_if.inject_heat;
    end
    if (load) begin
      heat_q <= ram_rdata[lfh_pkg::HEAT_W-1:lfh_pkg::HEAT_W-lfh_pkg::PIX_W];
      idx_q  <= lfh_pkg::IDX_W'(ld_q);
      last_q <= ld_last;
    end
  end

  assign out_if.valid       = ov_q;
  assign out_if.pixel_heat  = heat_q;
  assign out_if.pixel_index = idx_q;
  assign out_if.last        = last_q;

  lfh_heat_unit u_heat (
    .clk_i      (clk_i),
    .ctrl_i     (hctrl),
    .store_ok_i (ok_q),
    .rdata_i    (ram_rdata),
    .amount_i   (amount_q),
    .inject_i   (inj_q),
    .wdata_o    (ram_wdata)
  );

  lfh_ram #(
    .WIDTH (lfh_pkg::HEAT_W),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an accepted frame starts its update walk at pixel 0
  a_start_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_UPD) && (cnt_q == '0))
    else $error("frame did not start update walk");

  // pending read data only exists during emission
  a_pend_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_EMIT))
    else $error("read pending outside emission");

  // loads never run ahead of issued reads
  a_issue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (iss_q >= CW'(ld_q)))
    else $error("emission load ahead of reads");

  // the last item of a frame ends the frame
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ld_last) |=> (state_q == ST_IDLE) && out_if.last && out_if.valid)
    else $error("frame did not end on last item");

endmodule

// ----- tb/sv/led_fire_heat_simulation_core_tb.sv -----
module led_fire_heat_simulation_core_tb;
  import lfh_pkg::*;

  localparam int unsigned NPIX = PIXELS_DEF;

  // One frame item on in_if
  typedef struct packed {
    logic [MS_W-1:0]  ms;
    logic [INJ_W-1:0] inj;
  } frame_t;

  // One pixel item on out_if
  typedef struct packed {
    logic [PIX_W-1:0] heat;
    logic [IDX_W-1:0] idx;
    logic             last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lfh_in_if  in_if ();
  lfh_out_if out_if ();

  led_fire_heat_simulation_core #(.PIXELS(NPIX)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Frames waiting for the driver, and pixel items the strip should emit.
  frame_t frame_q[$];
  pixel_t px_exp_q[$];

  // Shadow of the strip: 8.8 heat per pixel plus the two registers.
  logic [HEAT_W-1:0] heat_mdl [NPIX];
  logic [COOL_W-1:0] cool_mdl;
  logic              rev_mdl;

  int unsigned mism_cnt;
  logic        in_taken;   // frame accepted at the last rising edge
  logic        idle_on;    // random idling allowed in this stretch
  int unsigned send_gap;
  int unsigned stall_cnt;

  always #4 clk_i = ~clk_i;

  // Cool, drift up, inject; then queue the PIXELS items of the frame.
  function automatic void advance_frame(frame_t f);
    logic [AMT_W-1:0] amount;
    logic [HEAT_W:0]  pair_sum;
    logic [8:0]       base;
    int               src;
    pixel_t           p;
    amount = AMT_W'(cool_mdl) * AMT_W'(f.ms);
    for (int i = 0; i < NPIX; i++) begin
      if (AMT_W'(heat_mdl[i]) > amount) begin
        heat_mdl[i] = heat_mdl[i] - amount[HEAT_W-1:0];
      end else begin
        heat_mdl[i] = '0;
      end
    end
    // heat rises: walk from the top so each pixel still sees the old values below
    for (int i = NPIX - 1; i >= 2; i--) begin
      pair_sum    = {1'b0, heat_mdl[i-1]} + {1'b0, heat_mdl[i-2]};
      heat_mdl[i] = pair_sum[HEAT_W:1];
    end
    heat_mdl[1] = heat_mdl[0] >> 1;
    // bottom pixel loses its fraction, then takes the new heat, capped at 255
    base = {1'b0, heat_mdl[0][15:8]} + {1'b0, f.inj};
    if (base > 9'd255) begin
      base = 9'd255;
    end
    heat_mdl[0] = {base[7:0], 8'h00};
    for (int k = 0; k < NPIX; k++) begin
      src    = rev_mdl ? (NPIX - 1 - k) : k;
      p.heat = heat_mdl[src][15:8];
      p.idx  = IDX_W'(k);
      p.last = (k == NPIX - 1);
      px_exp_q.push_back(p);
    end
  endfunction

  // Input side monitor plus output checker, sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        got.heat = out_if.pixel_heat;
        got.idx  = out_if.pixel_index;
        got.last = out_if.last;
        if (px_exp_q.size() == 0) begin
          if (mism_cnt < 10) begin
            $display("%0t: unexpected pixel item heat=%0d idx=%0d last=%0b",
                     $realtime, got.heat, got.idx, got.last);
          end
          mism_cnt++;
        end else begin
          want = px_exp_q.pop_front();
          if (got.heat !== want.heat || got.idx !== want.idx || got.last !== want.last) begin
            if (mism_cnt < 10) begin
              $display("%0t: pixel mismatch exp heat=%0d idx=%0d last=%0b",
                       $realtime, want.heat, want.idx, want.last);
              $display("%0t:                got heat=%0d idx=%0d last=%0b",
                       $realtime, got.heat, got.idx, got.last);
            end
            mism_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        advance_frame({in_if.ms_elapsed, in_if.inject_heat});
      end
    end
  end

  // Frame driver: holds valid until taken, random gaps between frames while idling is on.
  always @(negedge clk_i) begin
    frame_t f;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (frame_q.size() > 0) begin
        f = frame_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.ms_elapsed  <= f.ms;
        in_if.inject_heat <= f.inj;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 15);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Pixel receiver: ready mostly high, stall bursts while idling is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 14);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic push_frame(input logic [MS_W-1:0] ms, input logic [INJ_W-1:0] inj);
    frame_q.push_back({ms, inj});
  endtask

  // Setup then access phase; shadow copy keeps only the register's low bits.
  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COOL) begin
      cool_mdl = data[COOL_W-1:0];
    end else begin
      rev_mdl = data[0];
    end
  endtask

  // Sender holds off until the strip has emitted everything, then lets the
  // last frame's tail settle before any register write.
  task automatic wait_drained();
    while (frame_q.size() != 0 || in_if.valid || px_exp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2 * NPIX + 8) @(negedge clk_i);
  endtask

  function automatic frame_t rand_frame();
    frame_t f;
    case ($urandom_range(0, 9))
      0:       f.ms = MS_W'($urandom());
      1:       f.ms = '0;
      default: f.ms = MS_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 3))
      0:       f.inj = 8'd255;
      1:       f.inj = 8'd0;
      2:       f.inj = INJ_W'($urandom_range(200, 255));
      default: f.inj = INJ_W'($urandom());
    endcase
    return f;
  endfunction

  function automatic logic [COOL_W-1:0] rand_cool();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return COOL_W'($urandom());
      default: return COOL_W'($urandom_range(1, 200));
    endcase
  endfunction

  initial begin
    logic [PDATA_W-1:0] wdata;
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_if.valid       = 1'b0;
    in_if.ms_elapsed  = '0;
    in_if.inject_heat = '0;
    out_if.ready      = 1'b0;
    mism_cnt  = 0;
    send_gap  = 0;
    stall_cnt = 0;
    idle_on   = 1'b1;
    cool_mdl  = COOL_RST;
    rev_mdl   = REV_RST;
    for (int i = 0; i < NPIX; i++) begin
      heat_mdl[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: full injection builds a column of heat, no-cool frames
    // let it rise, a huge cooling step wipes the strip.
    push_frame(16'd0, 8'd255);
    push_frame(16'd0, 8'd255);
    push_frame(16'd1, 8'd255);
    push_frame(16'd0, 8'd0);
    push_frame(16'd3, 8'd128);
    push_frame(16'hFFFF, 8'd0);
    push_frame(16'd0, 8'd1);
    wait_drained();

    // No cooling at all even at the longest frame, top pixel emitted first.
    apb_write(REG_COOL, 32'd0);
    apb_write(REG_REV, 32'd1);
    push_frame(16'hFFFF, 8'd255);
    push_frame(16'hFFFF, 8'd255);
    push_frame(16'hFFFF, 8'd170);
    push_frame(16'd0, 8'd85);
    push_frame(16'd0, 8'd0);
    wait_drained();

    // Over-wide writes: only low bits land, so cool_rate max and bottom-first.
    // Max rate times max time is the largest cooling amount.
    apb_write(REG_COOL, 32'hDEAD_FFFF);
    apb_write(REG_REV, 32'hFFFF_FFFE);
    push_frame(16'd0, 8'd255);
    push_frame(16'd1, 8'd255);
    push_frame(16'hFFFF, 8'd255);
    push_frame(16'd0, 8'd255);
    wait_drained();

    // Slow cooling so fractions survive and truncation in averaging shows.
    apb_write(REG_COOL, 32'd1);
    apb_write(REG_REV, 32'd1);
    push_frame(16'd1, 8'd201);
    push_frame(16'd7, 8'd255);
    push_frame(16'd2, 8'd17);
    push_frame(16'd13, 8'd99);
    wait_drained();

    // Random part: five stretches with fresh settings; the second and the
    // last run with no idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      idle_on = !(ph == 1 || ph == 4);
      wdata = $urandom();
      wdata[COOL_W-1:0] = rand_cool();
      apb_write(REG_COOL, wdata);
      apb_write(REG_REV, $urandom());
      for (int n = 0; n < 20; n++) begin
        frame_q.push_back(rand_frame());
      end
      wait_drained();
    end

    if (mism_cnt == 0 && px_exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
